### design/rgd_pkg.sv
// ============================================================================
// rgd_pkg: shared types and constants of the RDS group decoder
// Record and result layouts, group codes and time arithmetic constants.
// ============================================================================
package rgd_pkg;

	localparam int NAME_LEN   = 8;
	localparam int TEXT_LEN   = 64;
	localparam int ROW_CHARS  = 4;
	localparam int TEXT_ROWS  = TEXT_LEN / ROW_CHARS;
	localparam int ROW_IDX_W  = $clog2(TEXT_ROWS);
	localparam int TEXT_IDX_W = $clog2(TEXT_LEN);

	localparam int IN_W  = 104;
	localparam int OUT_W = 104;

	localparam logic [4:0] GROUP_0A = 5'd0;
	localparam logic [4:0] GROUP_2A = 5'd4;
	localparam logic [4:0] GROUP_4A = 5'd8;

	localparam logic [7:0] FILL_CHAR = 8'h2E;

	localparam logic [12:0] DAY_MINUTES  = 13'd1440;
	localparam logic [10:0] HOUR_MINUTES = 11'd60;
	localparam logic [9:0]  HALF_HOUR    = 10'd30;
	// floor(x * 1093 / 2^16) equals floor(x / 60) for every x below 1440.
	localparam logic [21:0] HOUR_RECIP   = 22'd1093;
	localparam int          RECIP_SHIFT  = 16;

	typedef logic [ROW_CHARS-1:0][7:0] text_row_t;

	typedef struct packed {
		logic [7:0]            resp_status1;
		logic [7:0]            resp_status2;
		logic [7:0]            fifo_used;
		logic [15:0]           block_a;
		logic [15:0]           block_b;
		logic [15:0]           block_c;
		logic [15:0]           block_d;
		logic [7:0]            block_errors;
		logic [TEXT_IDX_W-1:0] read_index;
	} rec_t;

	typedef struct packed {
		logic        record_valid;
		logic [15:0] pi_code;
		logic        pi_changed;
		logic [63:0] station_name;
		logic        name_ready;
		logic [4:0]  local_hours;
		logic [5:0]  local_minutes;
		logic [7:0]  text_char;
	} res_t;

endpackage

### design/rgd_time.sv
// ============================================================================
// rgd_time: local time decoder
// Applies the half-hour offset to the UTC time and wraps it into one day.
// ============================================================================
module rgd_time (
	input  logic [4:0] utc_hour,
	input  logic [5:0] utc_minute,
	input  logic [4:0] offset,
	input  logic       offset_neg,
	output logic [4:0] hours,
	output logic [5:0] minutes
);
	import rgd_pkg::*;

	logic [10:0]        base;
	logic [9:0]         off_min;
	logic signed [12:0] total;
	logic [12:0]        wrapped;
	logic [10:0]        day_min;
	logic [21:0]        prod;
	logic [10:0]        min_full;

	always_comb begin
		base    = 11'(utc_hour) * HOUR_MINUTES + 11'(utc_minute);
		off_min = 10'(offset) * HALF_HOUR;
		if (offset_neg) begin
			total = $signed({2'b00, base}) - $signed({3'b000, off_min});
		end else begin
			total = $signed({2'b00, base}) + $signed({3'b000, off_min});
		end
		// The sum lies within one day either side, so one correction suffices.
		if (total[12]) begin
			wrapped = 13'(total) + DAY_MINUTES;
		end else if (13'(total) >= DAY_MINUTES) begin
			wrapped = 13'(total) - DAY_MINUTES;
		end else begin
			wrapped = 13'(total);
		end
		day_min  = wrapped[10:0];
		prod     = 22'(day_min) * HOUR_RECIP;
		hours    = prod[RECIP_SHIFT +: 5];
		min_full = day_min - 11'(hours) * HOUR_MINUTES;
		minutes  = min_full[5:0];
	end

endmodule

### design/rgd_state.sv
// ============================================================================
// rgd_state: decoder state and per-record update
// Holds PI, station name, radiotext and time, and forms the result of a record.
// ============================================================================
module rgd_state (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          upd,
	input  rgd_pkg::rec_t rec,
	output rgd_pkg::res_t res
);
	import rgd_pkg::*;

	logic [15:0] pi_q;
	logic [7:0]  name_q [NAME_LEN];
	logic [7:0]  prev_q [NAME_LEN];
	text_row_t   text_q [TEXT_ROWS];
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;

	logic [7:0]  name_base [NAME_LEN];
	logic [7:0]  name_d [NAME_LEN];
	logic [7:0]  prev_d [NAME_LEN];
	logic        ok;
	logic        changed;
	logic [4:0]  group;
	logic        wr_name;
	logic        wr_text;
	logic        wr_time;
	text_row_t   new_row;
	text_row_t   rd_row_val;
	logic [ROW_IDX_W-1:0] rd_row;
	logic [4:0]  time_hours;
	logic [5:0]  time_minutes;
	logic        has_fill;
	logic        differs;
	logic [63:0] name_flat;

	rgd_time u_time (
		.utc_hour   ({rec.block_c[0], rec.block_d[15:12]}),
		.utc_minute (rec.block_d[11:6]),
		.offset     (rec.block_d[4:0]),
		.offset_neg (rec.block_d[5]),
		.hours      (time_hours),
		.minutes    (time_minutes)
	);

	always_comb begin
		ok = rec.resp_status1[0] && !rec.resp_status1[1] && !rec.resp_status2[2]
			&& (rec.fifo_used != 8'd0)
			&& (rec.block_errors[1:0] != 2'b11) && (rec.block_errors[3:2] != 2'b11)
			&& (rec.block_errors[5:4] != 2'b11) && (rec.block_errors[7:6] != 2'b11);
		changed = ok && (rec.block_a != pi_q);
		group   = rec.block_b[15:11];
		wr_name = ok && (group == GROUP_0A);
		wr_text = ok && (group == GROUP_2A);
		wr_time = ok && (group == GROUP_4A);
		new_row = {rec.block_c, rec.block_d};

		has_fill  = 1'b0;
		differs   = 1'b0;
		name_flat = '0;
		for (int k = 0; k < NAME_LEN; k++) begin
			name_base[k] = changed ? FILL_CHAR : name_q[k];
			// The displaced pair is the one after any refill.
			if (wr_name && (2'(k >> 1) == rec.block_b[1:0])) begin
				name_d[k] = (k % 2 == 1) ? rec.block_d[7:0] : rec.block_d[15:8];
				prev_d[k] = name_base[k];
			end else begin
				name_d[k] = name_base[k];
				prev_d[k] = prev_q[k];
			end
			if (name_d[k] == FILL_CHAR) begin
				has_fill = 1'b1;
			end
			if (name_d[k] != prev_d[k]) begin
				differs = 1'b1;
			end
			name_flat[8*(NAME_LEN-1-k) +: 8] = name_d[k];
		end

		rd_row = rec.read_index[TEXT_IDX_W-1:2];
		if (wr_text && (rec.block_b[3:0] == rd_row)) begin
			rd_row_val = new_row;
		end else if (changed) begin
			rd_row_val = {ROW_CHARS{FILL_CHAR}};
		end else begin
			rd_row_val = text_q[rd_row];
		end

		res.record_valid  = ok;
		res.pi_code       = changed ? rec.block_a : pi_q;
		res.pi_changed    = changed;
		res.station_name  = name_flat;
		res.name_ready    = !has_fill && differs;
		res.local_hours   = wr_time ? time_hours : hour_q;
		res.local_minutes = wr_time ? time_minutes : minute_q;
		res.text_char     = rd_row_val[2'd3 - rec.read_index[1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pi_q     <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			for (int k = 0; k < NAME_LEN; k++) begin
				name_q[k] <= '0;
				prev_q[k] <= '0;
			end
			for (int r = 0; r < TEXT_ROWS; r++) begin
				text_q[r] <= '0;
			end
		end else if (upd) begin
			if (changed) begin
				pi_q <= rec.block_a;
			end
			if (wr_time) begin
				hour_q   <= time_hours;
				minute_q <= time_minutes;
			end
			for (int k = 0; k < NAME_LEN; k++) begin
				name_q[k] <= name_d[k];
				prev_q[k] <= prev_d[k];
			end
			for (int r = 0; r < TEXT_ROWS; r++) begin
				if (wr_text && (rec.block_b[3:0] == 4'(r))) begin
					text_q[r] <= new_row;
				end else if (changed) begin
					text_q[r] <= {ROW_CHARS{FILL_CHAR}};
				end
			end
		end
	end

endmodule

### design/rds_group_decoder.sv
// ============================================================================
// rds_group_decoder: RDS group 0A/2A/4A decoder
// Stream wrapper with an input register and a result register.
// ============================================================================
// One tuner RDS status record enters per transaction on the s_ channel and
// produces exactly one result transaction on the m_ channel. Invalid records
// leave the state untouched and are reported with record_valid low.
// A record is captured in the input register, decoded by one pass of
// combinational logic, and lands in the result register together with the
// state update.
// Throughput is one record per cycle while the receiver accepts results: the
// input register refills in the same cycle as it hands its record on, set
// only by the decode pass to the result register.
// When the receiver holds m_tready low, the result stays in place, the input
// register still takes one more record, and s_tready falls only once both are
// full. Reset empties both registers and clears the PI code, name, radiotext
// and time to zero.
// ============================================================================
module rds_group_decoder (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// resp_status1, resp_status2, fifo_used, block_a, block_b, block_c,
	// block_d, block_errors, read_index, zero padding
	input  logic [rgd_pkg::IN_W-1:0]  s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// record_valid, pi_code, pi_changed, station_name, name_ready,
	// local_hours, local_minutes, text_char, zero padding
	output logic [rgd_pkg::OUT_W-1:0] m_tdata
);
	import rgd_pkg::*;

	logic s1_valid;
	rec_t rec_s1;
	rec_t rec_in;
	res_t res;
	res_t res_s2;
	logic out_free;
	logic adv;

	assign rec_in.resp_status1 = s_tdata[7:0];
	assign rec_in.resp_status2 = s_tdata[15:8];
	assign rec_in.fifo_used    = s_tdata[23:16];
	assign rec_in.block_a      = s_tdata[39:24];
	assign rec_in.block_b      = s_tdata[55:40];
	assign rec_in.block_c      = s_tdata[71:56];
	assign rec_in.block_d      = s_tdata[87:72];
	assign rec_in.block_errors = s_tdata[95:88];
	assign rec_in.read_index   = s_tdata[101:96];

	assign out_free = !m_tvalid || m_tready;
	assign adv      = s1_valid && out_free;
	assign s_tready = !s1_valid || out_free;

	rgd_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.rec    (rec_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid <= s_tvalid;
			end
			if (out_free) begin
				m_tvalid <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rec_s1 <= rec_in;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {2'b00, res_s2.text_char, res_s2.local_minutes, res_s2.local_hours,
		res_s2.name_ready, res_s2.station_name, res_s2.pi_changed, res_s2.pi_code,
		res_s2.record_valid};

endmodule
